// File: design/apt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apt_pkg: shared constants and types for the affine point transform
// Fixed-point widths, configuration register codes and pipeline advance struct.
// ----------------------------------------------------------------------------
package apt_pkg;

  localparam int COORD_BITS      = 32;
  localparam int COEFF_FRAC_BITS = 12;
  localparam int COEFF_BITS      = 16;
  localparam int ROW_BITS        = 3 * COEFF_BITS;
  localparam int PROD_BITS       = COEFF_BITS + COORD_BITS;
  localparam int SUM_BITS        = PROD_BITS + 2;
  localparam int SHIFT_BITS      = SUM_BITS - COEFF_FRAC_BITS;
  localparam int ACC_BITS        = SHIFT_BITS + 1;
  localparam int DATA_BITS       = ((3 * COORD_BITS + 7) / 8) * 8;
  localparam int CFG_INDEX_BITS  = 3;

  localparam logic [COEFF_BITS-1:0] COEFF_ONE = COEFF_BITS'(1) << COEFF_FRAC_BITS;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ROW0     = 3'd0,
    REG_ROW1     = 3'd1,
    REG_ROW2     = 3'd2,
    REG_OFFSET_X = 3'd3,
    REG_OFFSET_Y = 3'd4,
    REG_OFFSET_Z = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } apt_adv_t;

endpackage
`default_nettype wire

// File: design/apt_row.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apt_row: one row of the affine transform
// Four stages: products, row sum, floor shift plus translation, saturation.
// ----------------------------------------------------------------------------
module apt_row import apt_pkg::*; (
  input  wire                          clk,
  input  wire  apt_adv_t               adv,
  input  wire  [ROW_BITS-1:0]          coeffs,
  input  wire  signed [COORD_BITS-1:0] offset,
  input  wire  signed [COORD_BITS-1:0] coord_x,
  input  wire  signed [COORD_BITS-1:0] coord_y,
  input  wire  signed [COORD_BITS-1:0] coord_z,
  input  wire                          is_direction,
  output logic signed [COORD_BITS-1:0] result,
  output logic                         ovf
);

  localparam logic signed [COORD_BITS-1:0] SAT_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] SAT_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic signed [COEFF_BITS-1:0] k0, k1, k2;
  logic signed [PROD_BITS-1:0]  prod0, prod1, prod2;
  logic                         point1, point2;
  logic signed [SUM_BITS-1:0]   sum;
  logic signed [SHIFT_BITS-1:0] shifted;
  logic signed [ACC_BITS-1:0]   acc;
  logic                         fits;

  assign k0 = coeffs[COEFF_BITS-1:0];
  assign k1 = coeffs[2*COEFF_BITS-1:COEFF_BITS];
  assign k2 = coeffs[3*COEFF_BITS-1:2*COEFF_BITS];

  assign shifted = $signed(sum[SUM_BITS-1:COEFF_FRAC_BITS]);

  assign fits = (&acc[ACC_BITS-1:COORD_BITS-1]) || !(|acc[ACC_BITS-1:COORD_BITS-1]);

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      prod0  <= k0 * coord_x;
      prod1  <= k1 * coord_y;
      prod2  <= k2 * coord_z;
      point1 <= !is_direction;
    end
    if (adv.s2) begin
      sum    <= SUM_BITS'(prod0) + SUM_BITS'(prod1) + SUM_BITS'(prod2);
      point2 <= point1;
    end
    if (adv.s3) begin
      acc <= ACC_BITS'(shifted) + (point2 ? ACC_BITS'(offset) : ACC_BITS'(0));
    end
    if (adv.s4) begin
      result <= fits ? acc[COORD_BITS-1:0] : (acc[ACC_BITS-1] ? SAT_MIN : SAT_MAX);
      ovf    <= !fits;
    end
  end

endmodule
`default_nettype wire

// File: design/affine_point_transform.sv
`default_nettype none
// ----------------------------------------------------------------------------
// affine_point_transform: 3x4 fixed-point vertex transform
// Input words on s_axis carry x, y, z (signed Q16.16) and a direction flag in
// tuser. Each component of the output word on m_axis is a row of the Q4.12
// linear part applied to the vector, floor-shifted by the fraction bits, plus
// the Q16.16 translation for points only, saturated to 32 bits; tuser carries
// the overflow flag, set when any component was clamped.
// Words pass the multiply, row sum, shift and translate, and saturate stages
// from input accept to output valid. One word is accepted every cycle unless
// the receiver stalls; the nine multipliers of the first stage set that figure.
// Each stage holds its own valid bit, so bubbles fill while the receiver
// stalls; s_axis_tready drops only when all four stages hold words.
// Reset empties the pipeline and loads the identity transform with zero
// translation. Write configuration through cfg_we/cfg_index/cfg_data while
// no word is in flight; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module affine_point_transform import apt_pkg::*; (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      cfg_we,
  input  wire [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire [ROW_BITS-1:0]       cfg_data,
  input  wire                      s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire [DATA_BITS-1:0]      s_axis_tdata,  // coord_x, coord_y, coord_z
  input  wire [0:0]                s_axis_tuser,  // is_direction
  output logic                     m_axis_tvalid,
  input  wire                      m_axis_tready,
  output logic [DATA_BITS-1:0]     m_axis_tdata,  // out_x, out_y, out_z
  output logic [0:0]               m_axis_tuser   // overflow
);

  logic [ROW_BITS-1:0]          row_coeffs [3];
  logic signed [COORD_BITS-1:0] offsets    [3];
  logic signed [COORD_BITS-1:0] results    [3];
  logic [2:0]                   ovfs;
  logic                         v1, v2, v3, v4;
  apt_adv_t                     adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_coeffs[0] <= ROW_BITS'(COEFF_ONE);
      row_coeffs[1] <= ROW_BITS'(COEFF_ONE) << COEFF_BITS;
      row_coeffs[2] <= ROW_BITS'(COEFF_ONE) << (2 * COEFF_BITS);
      offsets[0]    <= '0;
      offsets[1]    <= '0;
      offsets[2]    <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROW0:     row_coeffs[0] <= cfg_data;
        REG_ROW1:     row_coeffs[1] <= cfg_data;
        REG_ROW2:     row_coeffs[2] <= cfg_data;
        REG_OFFSET_X: offsets[0]    <= cfg_data[COORD_BITS-1:0];
        REG_OFFSET_Y: offsets[1]    <= cfg_data[COORD_BITS-1:0];
        REG_OFFSET_Z: offsets[2]    <= cfg_data[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // advance a stage when it is empty or the next one advances
  always_comb begin
    adv.s4 = !v4 || m_axis_tready;
    adv.s3 = !v3 || adv.s4;
    adv.s2 = !v2 || adv.s3;
    adv.s1 = !v1 || adv.s2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv.s1) v1 <= s_axis_tvalid;
      if (adv.s2) v2 <= v1;
      if (adv.s3) v3 <= v2;
      if (adv.s4) v4 <= v3;
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_row
    apt_row u_row (
      .clk          (clk),
      .adv          (adv),
      .coeffs       (row_coeffs[r]),
      .offset       (offsets[r]),
      .coord_x      (s_axis_tdata[COORD_BITS-1:0]),
      .coord_y      (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
      .coord_z      (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
      .is_direction (s_axis_tuser[0]),
      .result       (results[r]),
      .ovf          (ovfs[r])
    );
  end

  assign s_axis_tready   = adv.s1;
  assign m_axis_tvalid   = v4;
  assign m_axis_tdata    = DATA_BITS'({results[2], results[1], results[0]});
  assign m_axis_tuser[0] = |ovfs;

  localparam logic [COORD_BITS-1:0] SAT_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] SAT_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  a_ovf_clamped: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |->
      results[0] == SAT_MAX || results[0] == SAT_MIN ||
      results[1] == SAT_MAX || results[1] == SAT_MIN ||
      results[2] == SAT_MAX || results[2] == SAT_MIN)
    else $error("overflow set with no clamped component");

  a_full_on_stall: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> v1 && v2 && v3 && v4 && !m_axis_tready)
    else $error("input stalled while the pipeline has a free stage");

  a_empty_after_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> !m_axis_tvalid && s_axis_tready)
    else $error("pipeline not empty after reset");

endmodule
`default_nettype wire
